// File: rtl/scgr_pkg.sv
// Shared types, constants and helper functions for the shaded circle grid raster.
package scgr_pkg;

    // Coordinate counter width inside a cell and the largest grid dimension.
    localparam int COORD_BITS = 11;
    localparam int GRID_MAX   = 16;

    // Fixed register field widths.
    localparam int SIZE_W     = 11;
    localparam int GRID_REG_W = 5;
    localparam int RAD_W      = 10;
    localparam int COLOR_W    = 24;
    localparam int BYTE_W     = 8;

    // Comparison and arithmetic widths derived from the above.
    localparam int CMP_W   = ((COORD_BITS > SIZE_W) ? COORD_BITS : SIZE_W) + 1;
    localparam int GRID_BITS = (GRID_MAX > 1) ? $clog2(GRID_MAX) : 1;
    localparam int GCMP_W  = ((GRID_BITS + 1) > GRID_REG_W) ? (GRID_BITS + 1) : GRID_REG_W;
    localparam int DS_W    = CMP_W + 1;
    localparam int SQ_W    = 2 * DS_W;
    localparam int SUM_W   = SQ_W + 1;
    localparam int RR_W    = 2 * RAD_W;
    localparam int N_W     = DS_W + 1;

    // Shade divider.
    localparam int QUOT_W    = 7;
    localparam int DIV_STEPS = QUOT_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam int SHADE_MAX = 128;

    // Queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;

    // Configuration port.
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        REG_CELL_WIDTH   = 3'd0,
        REG_CELL_HEIGHT  = 3'd1,
        REG_GRID_COLS    = 3'd2,
        REG_GRID_ROWS    = 3'd3,
        REG_DISK_RADIUS  = 3'd4,
        REG_SHADOW_SHIFT = 3'd5,
        REG_DISK_COLOR   = 3'd6,
        REG_SHADOW_COLOR = 3'd7
    } reg_idx_t;

    localparam logic [SIZE_W-1:0]     RST_CELL_WIDTH   = 11'd320;
    localparam logic [SIZE_W-1:0]     RST_CELL_HEIGHT  = 11'd180;
    localparam logic [GRID_REG_W-1:0] RST_GRID_COLS    = 5'd6;
    localparam logic [GRID_REG_W-1:0] RST_GRID_ROWS    = 5'd6;
    localparam logic [RAD_W-1:0]      RST_DISK_RADIUS  = 10'd60;
    localparam logic [RAD_W-1:0]      RST_SHADOW_SHIFT = 10'd10;
    localparam logic [COLOR_W-1:0]    RST_DISK_COLOR   = 24'hFFFFFF;
    localparam logic [COLOR_W-1:0]    RST_SHADOW_COLOR = 24'h505050;

    localparam logic [BYTE_W-1:0] BG_BYTE0 = 8'h00;
    localparam logic [BYTE_W-1:0] BG_BYTE1 = 8'hFF;
    localparam logic [BYTE_W-1:0] BG_BYTE2 = 8'h00;

    typedef struct packed {
        logic [SIZE_W-1:0]     cell_width;
        logic [SIZE_W-1:0]     cell_height;
        logic [GRID_REG_W-1:0] grid_cols;
        logic [GRID_REG_W-1:0] grid_rows;
        logic [RAD_W-1:0]      disk_radius;
        logic [RAD_W-1:0]      shadow_shift;
        logic [COLOR_W-1:0]    disk_color;
        logic [COLOR_W-1:0]    shadow_color;
    } cfg_t;

    // One pixel slot as classified by the front part.
    typedef struct packed {
        logic signed [CMP_W-1:0] dx;
        logic signed [CMP_W-1:0] dy;
        logic                    line_end;
        logic                    frame_end;
    } item_t;

    function automatic logic [SIZE_W-1:0] size_at_least_one(input logic [SIZE_W-1:0] v);
        return (v == '0) ? SIZE_W'(1) : v;
    endfunction

    function automatic logic [GCMP_W-1:0] grid_limit(input logic [GRID_REG_W-1:0] v);
        logic [GCMP_W-1:0] ext;
        ext = GCMP_W'(v);
        if (ext == '0) begin
            ext = GCMP_W'(1);
        end
        if (ext > GCMP_W'(GRID_MAX)) begin
            ext = GCMP_W'(GRID_MAX);
        end
        return ext;
    endfunction

endpackage

// File: rtl/shaded_circle_grid_raster.sv
// Top level of the shaded circle grid raster: config bank, front, queue and back.
// The back sequencer handles one word at a time (load, square, compare, optional
// divide, output) and takes the next word from the queue only after the last one
// has reached the result register; only shaded disk pixels need the 7-step divider.
// Reset: rst_n clears the raster counters, the queue and the result valid flag at once
// and loads the configuration registers with their default values.
module shaded_circle_grid_raster (
    input  logic                         clk,
    input  logic                         rst_n,
    // Configuration port.
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [scgr_pkg::ADDR_W-1:0]  paddr,
    input  logic [scgr_pkg::DATA_W-1:0]  pwdata,
    output logic [scgr_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    // Pixel slot input.
    input  logic                         push,
    output logic                         full,
    input  logic                         frame_start,
    // Pixel result output.
    output logic                         empty,
    input  logic                         pop,
    output logic [scgr_pkg::BYTE_W-1:0]  pixel_byte0,
    output logic [scgr_pkg::BYTE_W-1:0]  pixel_byte1,
    output logic [scgr_pkg::BYTE_W-1:0]  pixel_byte2,
    output logic                         line_end,
    output logic                         frame_end
);

    // The register bank holds the grid geometry and colors. Writes must happen only while
    // the block is idle; the block does not enforce this. Every part reads the registers directly.
    scgr_pkg::cfg_t  cfg;

    // Words travelling from the front part through the queue to the back part.
    scgr_pkg::item_t wr_item;
    scgr_pkg::item_t rd_item;
    logic            q_wr;
    logic            q_full;
    logic            q_rd;
    logic            q_empty;

    scgr_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The front part owns the raster counters. It accepts a slot whenever the
    // queue has room, turns the counters into the pixel's offset from the cell
    // center and tags the last pixel of a line and of the frame.
    scgr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .push        (push),
        .frame_start (frame_start),
        .q_full      (q_full),
        .full        (full),
        .q_wr        (q_wr),
        .q_item      (wr_item)
    );

    // The queue lets the front keep taking slots while the back works on a
    // slower word or waits for the consumer to pop a result.
    scgr_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wr_item (wr_item),
        .full    (q_full),
        .rd      (q_rd),
        .rd_item (rd_item),
        .empty   (q_empty)
    );

    // The back part squares the offsets, tests disk and shadow, runs the shade
    // divider when needed and parks the finished pixel in the result register.
    scgr_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .q_item      (rd_item),
        .q_empty     (q_empty),
        .q_rd        (q_rd),
        .pop         (pop),
        .empty       (empty),
        .pixel_byte0 (pixel_byte0),
        .pixel_byte1 (pixel_byte1),
        .pixel_byte2 (pixel_byte2),
        .line_end    (line_end),
        .frame_end   (frame_end)
    );

endmodule

// File: rtl/scgr_cfg.sv
// Configuration register bank with an APB-style access port.
module scgr_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [scgr_pkg::ADDR_W-1:0]  paddr,
    input  logic [scgr_pkg::DATA_W-1:0]  pwdata,
    output logic [scgr_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output scgr_pkg::cfg_t               cfg
);

    localparam int DW = scgr_pkg::DATA_W;

    scgr_pkg::cfg_t     cfg_reg;
    scgr_pkg::cfg_t     cfg_next;
    scgr_pkg::reg_idx_t idx;
    logic               wr_en;

    assign pready = 1'b1;
    assign idx    = scgr_pkg::reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                scgr_pkg::REG_CELL_WIDTH:
                    cfg_next.cell_width = pwdata[scgr_pkg::SIZE_W-1:0];
                scgr_pkg::REG_CELL_HEIGHT:
                    cfg_next.cell_height = pwdata[scgr_pkg::SIZE_W-1:0];
                scgr_pkg::REG_GRID_COLS:
                    cfg_next.grid_cols = pwdata[scgr_pkg::GRID_REG_W-1:0];
                scgr_pkg::REG_GRID_ROWS:
                    cfg_next.grid_rows = pwdata[scgr_pkg::GRID_REG_W-1:0];
                scgr_pkg::REG_DISK_RADIUS:
                    cfg_next.disk_radius = pwdata[scgr_pkg::RAD_W-1:0];
                scgr_pkg::REG_SHADOW_SHIFT:
                    cfg_next.shadow_shift = pwdata[scgr_pkg::RAD_W-1:0];
                scgr_pkg::REG_DISK_COLOR:
                    cfg_next.disk_color = pwdata[scgr_pkg::COLOR_W-1:0];
                scgr_pkg::REG_SHADOW_COLOR:
                    cfg_next.shadow_color = pwdata[scgr_pkg::COLOR_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            scgr_pkg::REG_CELL_WIDTH:   prdata = DW'(cfg_reg.cell_width);
            scgr_pkg::REG_CELL_HEIGHT:  prdata = DW'(cfg_reg.cell_height);
            scgr_pkg::REG_GRID_COLS:    prdata = DW'(cfg_reg.grid_cols);
            scgr_pkg::REG_GRID_ROWS:    prdata = DW'(cfg_reg.grid_rows);
            scgr_pkg::REG_DISK_RADIUS:  prdata = DW'(cfg_reg.disk_radius);
            scgr_pkg::REG_SHADOW_SHIFT: prdata = DW'(cfg_reg.shadow_shift);
            scgr_pkg::REG_DISK_COLOR:   prdata = DW'(cfg_reg.disk_color);
            scgr_pkg::REG_SHADOW_COLOR: prdata = DW'(cfg_reg.shadow_color);
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cell_width   <= scgr_pkg::RST_CELL_WIDTH;
            cfg_reg.cell_height  <= scgr_pkg::RST_CELL_HEIGHT;
            cfg_reg.grid_cols    <= scgr_pkg::RST_GRID_COLS;
            cfg_reg.grid_rows    <= scgr_pkg::RST_GRID_ROWS;
            cfg_reg.disk_radius  <= scgr_pkg::RST_DISK_RADIUS;
            cfg_reg.shadow_shift <= scgr_pkg::RST_SHADOW_SHIFT;
            cfg_reg.disk_color   <= scgr_pkg::RST_DISK_COLOR;
            cfg_reg.shadow_color <= scgr_pkg::RST_SHADOW_COLOR;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: rtl/scgr_front.sv
// Front part: raster counters and classification of each accepted pixel slot.
module scgr_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  scgr_pkg::cfg_t       cfg,
    input  logic                 push,
    input  logic                 frame_start,
    input  logic                 q_full,
    output logic                 full,
    output logic                 q_wr,
    output scgr_pkg::item_t      q_item
);

    localparam int XW = scgr_pkg::COORD_BITS;
    localparam int GB = scgr_pkg::GRID_BITS;
    localparam int CW = scgr_pkg::CMP_W;
    localparam int GW = scgr_pkg::GCMP_W;

    logic [XW-1:0] local_x_reg, local_x_next;
    logic [XW-1:0] local_y_reg, local_y_next;
    logic [GB-1:0] cell_col_reg, cell_col_next;
    logic [GB-1:0] cell_row_reg, cell_row_next;

    logic [XW-1:0] cur_x, cur_y;
    logic [GB-1:0] cur_col, cur_row;
    logic [scgr_pkg::SIZE_W-1:0] w, h;
    logic [GW-1:0] nc, nr;
    logic [CW-1:0] x_ext, y_ext;
    logic          x_last, col_last, y_last, row_last;
    logic          accept;

    assign full   = q_full;
    assign accept = push && !q_full;
    assign q_wr   = accept;

    always_comb
    begin
        // A frame start clears every counter ahead of this pixel.
        cur_x   = frame_start ? '0 : local_x_reg;
        cur_y   = frame_start ? '0 : local_y_reg;
        cur_col = frame_start ? '0 : cell_col_reg;
        cur_row = frame_start ? '0 : cell_row_reg;

        w  = scgr_pkg::size_at_least_one(cfg.cell_width);
        h  = scgr_pkg::size_at_least_one(cfg.cell_height);
        nc = scgr_pkg::grid_limit(cfg.grid_cols);
        nr = scgr_pkg::grid_limit(cfg.grid_rows);

        x_ext = CW'(cur_x);
        y_ext = CW'(cur_y);

        // A counter at or past its limit counts as being on its last value.
        x_last   = (x_ext + CW'(1)) >= CW'(w);
        y_last   = (y_ext + CW'(1)) >= CW'(h);
        col_last = (GW'(cur_col) + GW'(1)) >= nc;
        row_last = (GW'(cur_row) + GW'(1)) >= nr;

        q_item.dx        = x_ext - CW'(w >> 1);
        q_item.dy        = y_ext - CW'(h >> 1);
        q_item.line_end  = x_last && col_last;
        q_item.frame_end = x_last && col_last && y_last && row_last;

        local_x_next  = cur_x;
        local_y_next  = cur_y;
        cell_col_next = cur_col;
        cell_row_next = cur_row;
        if (!x_last)
        begin
            local_x_next = cur_x + XW'(1);
        end
        else
        begin
            local_x_next = '0;
            if (!col_last)
            begin
                cell_col_next = cur_col + GB'(1);
            end
            else
            begin
                cell_col_next = '0;
                if (!y_last)
                begin
                    local_y_next = cur_y + XW'(1);
                end
                else
                begin
                    local_y_next  = '0;
                    cell_row_next = row_last ? '0 : (cur_row + GB'(1));
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_x_reg  <= '0;
            local_y_reg  <= '0;
            cell_col_reg <= '0;
            cell_row_reg <= '0;
        end
        else if (accept)
        begin
            local_x_reg  <= local_x_next;
            local_y_reg  <= local_y_next;
            cell_col_reg <= cell_col_next;
            cell_row_reg <= cell_row_next;
        end
    end

endmodule

// File: rtl/scgr_queue.sv
// Short word queue that decouples the front part from the back part.
module scgr_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr,
    input  scgr_pkg::item_t wr_item,
    output logic            full,
    input  logic            rd,
    output scgr_pkg::item_t rd_item,
    output logic            empty
);

    localparam int DEPTH = scgr_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW    = $clog2(DEPTH + 1);

    scgr_pkg::item_t slot_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]   count_reg, count_next;
    logic            do_wr, do_rd;

    assign full    = (count_reg == NW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr && !full;
    assign do_rd   = rd && !empty;
    assign rd_item = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : (wr_ptr_reg + PW'(1));
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : (rd_ptr_reg + PW'(1));
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + NW'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - NW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/scgr_back.sv
// Back part: disk and shadow tests, shade divider and the result register.
module scgr_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  scgr_pkg::cfg_t               cfg,
    input  scgr_pkg::item_t              q_item,
    input  logic                         q_empty,
    output logic                         q_rd,
    input  logic                         pop,
    output logic                         empty,
    output logic [scgr_pkg::BYTE_W-1:0]  pixel_byte0,
    output logic [scgr_pkg::BYTE_W-1:0]  pixel_byte1,
    output logic [scgr_pkg::BYTE_W-1:0]  pixel_byte2,
    output logic                         line_end,
    output logic                         frame_end
);

    localparam int CW  = scgr_pkg::CMP_W;
    localparam int DSW = scgr_pkg::DS_W;
    localparam int SQW = scgr_pkg::SQ_W;
    localparam int SMW = scgr_pkg::SUM_W;
    localparam int RRW = scgr_pkg::RR_W;
    localparam int NW  = scgr_pkg::N_W;
    localparam int RW  = scgr_pkg::RAD_W;
    localparam int QW  = scgr_pkg::QUOT_W;
    localparam int SW  = scgr_pkg::STEP_W;
    localparam int BW  = scgr_pkg::BYTE_W;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SQR  = 5'b00010,
        ST_CMP  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    typedef enum logic [1:0] {
        CLS_BG,
        CLS_DISK,
        CLS_SHADOW
    } pix_class_t;

    state_t     state_reg, state_next;
    pix_class_t cls_reg, cls_next;

    logic signed [DSW-1:0] dx_reg, dx_next, dy_reg, dy_next;
    logic signed [DSW-1:0] dxs_reg, dxs_next, dys_reg, dys_next;
    logic signed [NW-1:0]  n_reg, n_next;
    logic                  le_reg, le_next, fe_reg, fe_next;
    logic [SQW-1:0]        sqx_reg, sqx_next, sqy_reg, sqy_next;
    logic [SQW-1:0]        sqxs_reg, sqxs_next, sqys_reg, sqys_next;
    logic [RRW-1:0]        rr_reg;
    logic [BW-1:0]         t_reg, t_next;
    logic [RW:0]           rem_reg, rem_next;
    logic [QW-1:0]         quot_reg, quot_next;
    logic [SW-1:0]         step_reg, step_next;

    logic                  out_valid_reg, out_valid_next;
    logic [BW-1:0]         b0_reg, b0_next, b1_reg, b1_next, b2_reg, b2_next;
    logic                  ole_reg, ole_next, ofe_reg, ofe_next;

    logic signed [DSW-1:0] dx_in, dy_in, s_in;
    logic                  in_disk, in_shadow, div_ge;
    logic [RW:0]           r_ext, div_diff;
    logic                  out_free;

    assign empty       = !out_valid_reg;
    assign pixel_byte0 = b0_reg;
    assign pixel_byte1 = b1_reg;
    assign pixel_byte2 = b2_reg;
    assign line_end    = ole_reg;
    assign frame_end   = ofe_reg;

    assign out_free = !out_valid_reg || pop;
    assign q_rd     = (state_reg == ST_IDLE) && !q_empty;

    always_comb
    begin
        dx_in = {{(DSW - CW){q_item.dx[CW-1]}}, q_item.dx};
        dy_in = {{(DSW - CW){q_item.dy[CW-1]}}, q_item.dy};
        s_in  = $signed({{(DSW - RW){1'b0}}, cfg.shadow_shift});
        r_ext = {1'b0, cfg.disk_radius};

        in_disk   = (SMW'(sqx_reg) + SMW'(sqy_reg)) <= SMW'(rr_reg);
        in_shadow = (SMW'(sqxs_reg) + SMW'(sqys_reg)) <= SMW'(rr_reg);

        // One restoring step of n * 64 / r per cycle.
        div_ge   = rem_reg >= r_ext;
        div_diff = div_ge ? (rem_reg - r_ext) : rem_reg;

        state_next     = state_reg;
        cls_next       = cls_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        dxs_next       = dxs_reg;
        dys_next       = dys_reg;
        n_next         = n_reg;
        le_next        = le_reg;
        fe_next        = fe_reg;
        sqx_next       = sqx_reg;
        sqy_next       = sqy_reg;
        sqxs_next      = sqxs_reg;
        sqys_next      = sqys_reg;
        t_next         = t_reg;
        rem_next       = rem_reg;
        quot_next      = quot_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !pop;
        b0_next        = b0_reg;
        b1_next        = b1_reg;
        b2_next        = b2_reg;
        ole_next       = ole_reg;
        ofe_next       = ofe_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    dx_next    = dx_in;
                    dy_next    = dy_in;
                    dxs_next   = dx_in - s_in;
                    dys_next   = dy_in - s_in;
                    n_next     = NW'(dx_in) + NW'(dy_in) + $signed(NW'(r_ext));
                    le_next    = q_item.line_end;
                    fe_next    = q_item.frame_end;
                    state_next = ST_SQR;
                end
            end
            ST_SQR:
            begin
                sqx_next   = SQW'(dx_reg) * SQW'(dx_reg);
                sqy_next   = SQW'(dy_reg) * SQW'(dy_reg);
                sqxs_next  = SQW'(dxs_reg) * SQW'(dxs_reg);
                sqys_next  = SQW'(dys_reg) * SQW'(dys_reg);
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                t_next     = '0;
                state_next = ST_OUT;
                if (in_disk)
                begin
                    cls_next = CLS_DISK;
                    if ((cfg.disk_radius == '0) || n_reg[NW-1] || (n_reg == '0))
                    begin
                        t_next = '0;
                    end
                    else if (n_reg >= $signed({{(NW - RW - 1){1'b0}}, cfg.disk_radius, 1'b0}))
                    begin
                        t_next = BW'(scgr_pkg::SHADE_MAX);
                    end
                    else
                    begin
                        rem_next   = n_reg[RW:0];
                        quot_next  = '0;
                        step_next  = '0;
                        state_next = ST_DIV;
                    end
                end
                else if (in_shadow)
                begin
                    cls_next = CLS_SHADOW;
                end
                else
                begin
                    cls_next = CLS_BG;
                end
            end
            ST_DIV:
            begin
                rem_next  = {div_diff[RW-1:0], 1'b0};
                quot_next = {quot_reg[QW-2:0], div_ge};
                step_next = step_reg + SW'(1);
                if (step_reg == SW'(scgr_pkg::DIV_STEPS - 1))
                begin
                    t_next     = {1'b0, quot_reg[QW-2:0], div_ge};
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    case (cls_reg)
                        CLS_DISK:
                        begin
                            b0_next = cfg.disk_color[7:0] - t_reg;
                            b1_next = cfg.disk_color[15:8] - t_reg;
                            b2_next = cfg.disk_color[23:16] - t_reg;
                        end
                        CLS_SHADOW:
                        begin
                            b0_next = cfg.shadow_color[7:0];
                            b1_next = cfg.shadow_color[15:8];
                            b2_next = cfg.shadow_color[23:16];
                        end
                        default:
                        begin
                            b0_next = scgr_pkg::BG_BYTE0;
                            b1_next = scgr_pkg::BG_BYTE1;
                            b2_next = scgr_pkg::BG_BYTE2;
                        end
                    endcase
                    ole_next       = le_reg;
                    ofe_next       = fe_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        cls_reg  <= cls_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        dxs_reg  <= dxs_next;
        dys_reg  <= dys_next;
        n_reg    <= n_next;
        le_reg   <= le_next;
        fe_reg   <= fe_next;
        sqx_reg  <= sqx_next;
        sqy_reg  <= sqy_next;
        sqxs_reg <= sqxs_next;
        sqys_reg <= sqys_next;
        rr_reg   <= RRW'(cfg.disk_radius) * RRW'(cfg.disk_radius);
        t_reg    <= t_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        step_reg <= step_next;
        b0_reg   <= b0_next;
        b1_reg   <= b1_next;
        b2_reg   <= b2_next;
        ole_reg  <= ole_next;
        ofe_reg  <= ofe_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: rtl/scgr_checker.sv
// Port-level assertion checker for the shaded circle grid raster and its bind.
module scgr_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         push,
    input logic                         full,
    input logic                         empty,
    input logic                         pop,
    input logic [scgr_pkg::BYTE_W-1:0]  pixel_byte0,
    input logic [scgr_pkg::BYTE_W-1:0]  pixel_byte1,
    input logic [scgr_pkg::BYTE_W-1:0]  pixel_byte2,
    input logic                         line_end,
    input logic                         frame_end
);

    // A waiting result that is not popped stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(pixel_byte0) && $stable(pixel_byte1)
            && $stable(pixel_byte2) && $stable(line_end) && $stable(frame_end)))
        else $error("result word changed while waiting");

    // The last pixel of a frame is always the last pixel of a line.
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (!frame_end || line_end))
        else $error("frame end without line end");

    // The queue can only fill up right after a word was taken in.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(full) |-> $past(push && !full))
        else $error("full rose without an accepted word");

endmodule

bind shaded_circle_grid_raster scgr_checker u_scgr_checker (.*);

// File: test/tb_top.sv
// Self-checking testbench for the shaded circle grid raster pixel generator.
`timescale 1ns / 100ps

module tb_top;
    import scgr_pkg::*;

    // Cycles the block may still need after the last result before it counts as idle.
    localparam int SETTLE_CYCLES = 12;

    // One expected or observed pixel word on the result side.
    typedef struct packed {
        logic [BYTE_W-1:0] byte0;
        logic [BYTE_W-1:0] byte1;
        logic [BYTE_W-1:0] byte2;
        logic              line_end;
        logic              frame_end;
    } pixel_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                push;
    logic                full;
    logic                frame_start;
    logic                empty;
    logic                pop;
    logic [BYTE_W-1:0]   pixel_byte0;
    logic [BYTE_W-1:0]   pixel_byte1;
    logic [BYTE_W-1:0]   pixel_byte2;
    logic                line_end;
    logic                frame_end;

    // Mirror of the configuration registers and of the raster counters.
    cfg_t        cfg;
    int unsigned pos_x;
    int unsigned pos_y;
    int unsigned cell_c;
    int unsigned cell_r;

    // Pixels predicted for accepted words, oldest first.
    pixel_t pending_pixels[$];

    // When set, neither side inserts gaps or stalls.
    bit no_gaps;

    int errors;
    int pixels_sent;
    int pixels_checked;
    int lines_seen;
    int frames_seen;
    int settings_used;

    shaded_circle_grid_raster u_dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Gap before a word is offered, or stall before a result is taken.
    function automatic int draw_wait();
        return no_gaps ? 0 : int'($urandom_range(0, 14));
    endfunction

    // Computes the pixel for the next slot in raster order and advances the counters.
    // A counter that sits at or past its last value, which happens when the grid
    // was made smaller in the middle of a frame, is treated as being at its last value.
    function automatic pixel_t raster_next_pixel(input logic start);
        int unsigned w;
        int unsigned h;
        int unsigned ncol;
        int unsigned nrow;
        longint      dx;
        longint      dy;
        longint      rad;
        longint      sft;
        longint      num;
        longint      shade;
        logic        x_last;
        logic        col_last;
        logic        y_last;
        logic        row_last;
        pixel_t      p;

        // Sizes of zero behave as one, grid sizes saturate at the grid limit.
        w    = (cfg.cell_width == 0) ? 1 : cfg.cell_width;
        h    = (cfg.cell_height == 0) ? 1 : cfg.cell_height;
        ncol = (cfg.grid_cols == 0) ? 1 : cfg.grid_cols;
        nrow = (cfg.grid_rows == 0) ? 1 : cfg.grid_rows;
        if (ncol > GRID_MAX)
        begin
            ncol = GRID_MAX;
        end
        if (nrow > GRID_MAX)
        begin
            nrow = GRID_MAX;
        end
        rad = cfg.disk_radius;
        sft = cfg.shadow_shift;

        if (start)
        begin
            pos_x  = 0;
            pos_y  = 0;
            cell_c = 0;
            cell_r = 0;
        end

        dx = longint'(pos_x) - longint'(w / 2);
        dy = longint'(pos_y) - longint'(h / 2);

        if (dx * dx + dy * dy <= rad * rad)
        begin
            // Diagonal shading, darker toward the lower right. A zero radius or a
            // nonpositive numerator gives no shading at all.
            num   = (dx + dy + rad) * SHADE_MAX;
            shade = 0;
            if (num > 0 && rad > 0)
            begin
                shade = num / (2 * rad);
                if (shade > SHADE_MAX)
                begin
                    shade = SHADE_MAX;
                end
            end
            p.byte0 = cfg.disk_color[7:0] - BYTE_W'(shade);
            p.byte1 = cfg.disk_color[15:8] - BYTE_W'(shade);
            p.byte2 = cfg.disk_color[23:16] - BYTE_W'(shade);
        end
        else if ((dx - sft) * (dx - sft) + (dy - sft) * (dy - sft) <= rad * rad)
        begin
            p.byte0 = cfg.shadow_color[7:0];
            p.byte1 = cfg.shadow_color[15:8];
            p.byte2 = cfg.shadow_color[23:16];
        end
        else
        begin
            p.byte0 = BG_BYTE0;
            p.byte1 = BG_BYTE1;
            p.byte2 = BG_BYTE2;
        end

        x_last   = (pos_x + 1 >= w);
        col_last = (cell_c + 1 >= ncol);
        y_last   = (pos_y + 1 >= h);
        row_last = (cell_r + 1 >= nrow);
        p.line_end  = x_last && col_last;
        p.frame_end = p.line_end && y_last && row_last;

        // Count order: column in cell, cell column, line in cell, cell row.
        if (!x_last)
        begin
            pos_x = pos_x + 1;
        end
        else
        begin
            pos_x = 0;
            if (!col_last)
            begin
                cell_c = cell_c + 1;
            end
            else
            begin
                cell_c = 0;
                if (!y_last)
                begin
                    pos_y = pos_y + 1;
                end
                else
                begin
                    pos_y  = 0;
                    cell_r = row_last ? 0 : cell_r + 1;
                end
            end
        end
        return p;
    endfunction

    // One register write: a setup phase, then an access phase that completes on pready.
    // Bits above the field are filled with noise, since the block keeps only the field.
    // psel stays high so that back to back writes need no second assignment per step.
    task automatic write_reg(input reg_idx_t idx, input int width, input logic [31:0] value);
        logic [31:0] noise;

        noise = $urandom;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= (noise << width) | value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
    endtask

    // Writes every register and updates the mirror. Only called while the block is idle.
    task automatic apply_config(input cfg_t c);
        write_reg(REG_CELL_WIDTH, SIZE_W, 32'(c.cell_width));
        write_reg(REG_CELL_HEIGHT, SIZE_W, 32'(c.cell_height));
        write_reg(REG_GRID_COLS, GRID_REG_W, 32'(c.grid_cols));
        write_reg(REG_GRID_ROWS, GRID_REG_W, 32'(c.grid_rows));
        write_reg(REG_DISK_RADIUS, RAD_W, 32'(c.disk_radius));
        write_reg(REG_SHADOW_SHIFT, RAD_W, 32'(c.shadow_shift));
        write_reg(REG_DISK_COLOR, COLOR_W, 32'(c.disk_color));
        write_reg(REG_SHADOW_COLOR, COLOR_W, 32'(c.shadow_color));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg = c;
        settings_used++;
    endtask

    // Offers one pixel slot word and records its expected pixel once it is taken.
    // push is lowered only ahead of a gap, so a gapless stream keeps it high.
    task automatic send_pixel(input logic start);
        int gap;

        gap = draw_wait();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push        <= 1'b1;
        frame_start <= start;
        do
            @(posedge clk);
        while (full);
        pending_pixels.push_back(raster_next_pixel(start));
        pixels_sent++;
    endtask

    // Stops offering words and waits until every predicted pixel has come out.
    task automatic drain_pixels();
        push <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endtask

    // Values out of reset, checked on the first pixels of a frame.
    task automatic test_reset_values();
        send_pixel(1'b1);
        send_pixel(1'b0);
        send_pixel(1'b0);
    endtask

    // All sizes zero and a zero radius: every slot is the lone center pixel of a
    // one-pixel frame, unshaded, and ends both its line and its frame.
    task automatic test_degenerate_sizes();
        cfg_t c;

        drain_pixels();
        c = '{11'd0, 11'd0, 5'd0, 5'd0, 10'd0, 10'd0, 24'h123456, 24'h654321};
        apply_config(c);
        send_pixel(1'b1);
        send_pixel(1'b0);
        send_pixel(1'b0);
    endtask

    // A one-line cell that lies wholly inside the disk, so the shade runs from the
    // nonpositive numerator at the left to the clamp at the right. Small color bytes
    // make the subtraction wrap. The grid sizes are past the limit and zero.
    task automatic test_shade_range();
        cfg_t c;

        drain_pixels();
        c = '{11'd11, 11'd1, 5'd31, 5'd0, 10'd5, 10'd0, 24'h00407F, 24'hABCDEF};
        apply_config(c);
        send_pixel(1'b1);
        repeat (10) send_pixel(1'b0);
    endtask

    // The grid shrinks under the running counters: the cell column is then past its
    // last value and has to be taken as the last one.
    task automatic test_shrunk_counters();
        cfg_t c;

        drain_pixels();
        c = cfg;
        c.cell_width  = 11'd3;
        c.cell_height = 11'd2;
        c.grid_cols   = 5'd1;
        c.grid_rows   = 5'd1;
        apply_config(c);
        repeat (4) send_pixel(1'b0);
    endtask

    // Cell sizes, radius, shift and disk color at their largest values, the grid at its limit.
    task automatic test_extremes();
        cfg_t c;

        drain_pixels();
        c = '{11'd2047, 11'd2047, 5'd16, 5'd16, 10'd1023, 10'd1023, 24'hFFFFFF, 24'h000000};
        apply_config(c);
        send_pixel(1'b1);
        send_pixel(1'b0);
        send_pixel(1'b0);
    endtask

    // Mostly cells that hold their disk and shadow, with small frames so frame ends
    // come often. Now and then a misfit: tiny cells, huge radius or shift, odd grids.
    function automatic cfg_t random_cfg();
        cfg_t        c;
        int unsigned rad;
        int unsigned sft;

        rad = $urandom_range(0, 3);
        sft = $urandom_range(0, 2);
        c.disk_radius  = RAD_W'(rad);
        c.shadow_shift = RAD_W'(sft);
        c.cell_width   = SIZE_W'(2 * (rad + sft) + 1 + $urandom_range(0, 2));
        c.cell_height  = SIZE_W'(2 * (rad + sft) + 1 + $urandom_range(0, 2));
        c.grid_cols    = GRID_REG_W'($urandom_range(1, 3));
        c.grid_rows    = GRID_REG_W'($urandom_range(1, 2));
        c.disk_color   = COLOR_W'($urandom);
        c.shadow_color = COLOR_W'($urandom);
        if ($urandom_range(0, 5) == 0)
        begin
            c.cell_width   = SIZE_W'($urandom_range(0, 6));
            c.disk_radius  = RAD_W'($urandom);
            c.shadow_shift = RAD_W'($urandom);
            c.grid_cols    = GRID_REG_W'($urandom);
        end
        return c;
    endfunction

    // Random settings in phases. The counters carry over from phase to phase, so a
    // new, smaller grid often meets counters past their limits. Most words continue
    // the frame; a rare frame start in the middle acts as noise.
    task automatic test_random_frames();
        logic start;

        for (int phase = 0; phase < 12; phase++)
        begin
            drain_pixels();
            no_gaps = (phase % 4 == 3);
            apply_config(random_cfg());
            for (int i = 0; i < 96; i++)
            begin
                start = ((i == 0) && ($urandom_range(0, 1) == 1)) ||
                        ($urandom_range(0, 99) == 0);
                send_pixel(start);
                // Once, hold the input back until the block has emptied out.
                if (phase == 5 && i == 48)
                begin
                    drain_pixels();
                end
            end
        end
        no_gaps = 1'b0;
    endtask

    // Result side: takes each pixel word after a random stall and compares it with
    // the oldest prediction.
    initial
    begin : pixel_checker
        int     stall;
        pixel_t want;

        stall = 0;
        pop <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                pixels_checked++;
                if (line_end === 1'b1)
                begin
                    lines_seen++;
                end
                if (frame_end === 1'b1)
                begin
                    frames_seen++;
                end
                if (pending_pixels.size() == 0)
                begin
                    $error("pixel word received with no pixel pending");
                    errors++;
                end
                else
                begin
                    want = pending_pixels.pop_front();
                    check_field("pixel_byte0", want.byte0, pixel_byte0);
                    check_field("pixel_byte1", want.byte1, pixel_byte1);
                    check_field("pixel_byte2", want.byte2, pixel_byte2);
                    check_field("line_end", 8'(want.line_end), 8'(line_end));
                    check_field("frame_end", 8'(want.frame_end), 8'(frame_end));
                end
                stall = draw_wait();
                if (stall > 0)
                begin
                    pop <= 1'b0;
                end
            end
            else if (!pop)
            begin
                if (stall > 0)
                begin
                    stall--;
                end
                if (stall == 0)
                begin
                    pop <= 1'b1;
                end
            end
        end
    end

    // Stimulus: reset, directed cases, random phases, then drain and report.
    initial
    begin : stimulus
        rst_n       <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        push        <= 1'b0;
        frame_start <= 1'b0;
        cfg = '{RST_CELL_WIDTH, RST_CELL_HEIGHT, RST_GRID_COLS, RST_GRID_ROWS,
                RST_DISK_RADIUS, RST_SHADOW_SHIFT, RST_DISK_COLOR, RST_SHADOW_COLOR};
        pos_x  = 0;
        pos_y  = 0;
        cell_c = 0;
        cell_r = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_degenerate_sizes();
        test_shade_range();
        test_shrunk_counters();
        test_extremes();
        test_random_frames();
        drain_pixels();

        $display("Run covered %0d register settings, %0d pixel words sent, %0d checked,",
                 settings_used, pixels_sent, pixels_checked);
        $display("with %0d line ends and %0d frame ends among the results.",
                 lines_seen, frames_seen);
        if (errors == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial
    begin : watchdog
        #5_000_000;
        $display("Timeout: %0d pixel words still pending", pending_pixels.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
